@@ src/tfh_pkg.sv @@
package tfh_pkg;

    localparam logic [31:0] HASH_SEED = 32'd1783256291;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_DEL  = 2'd1;
    localparam logic [1:0] CMD_FIND = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [7:0]  proto;
        logic [15:0] id;
    } entry_t;

    typedef struct packed {
        logic id_hit;
        logic key_hit;
    } cmp_t;

    function automatic logic [31:0] key_hash(input logic [31:0] src,
                                             input logic [31:0] dst,
                                             input logic [7:0]  proto);
        logic [31:0] h;
        h = HASH_SEED ^ dst;
        h = h ^ ((h << 7) ^ src ^ (h >> 3));
        h = h ^ ~((h << 11) ^ {24'd0, proto} ^ (h >> 5));
        h = h ^ (h >> 16);
        return h;
    endfunction

endpackage

@@ src/tfh_ram.sv @@
module tfh_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/tfh_cmp.sv @@
module tfh_cmp (
    input  tfh_pkg::entry_t ent,
    input  logic [31:0]     src_addr,
    input  logic [31:0]     dst_addr,
    input  logic [7:0]      protocol,
    input  logic [15:0]     tunnel_id,
    output tfh_pkg::cmp_t   result
);

    import tfh_pkg::*;

    always_comb
    begin
        result.id_hit  = (ent.id == tunnel_id);
        result.key_hit = (ent.src == src_addr) && (ent.dst == dst_addr) &&
                         (ent.proto == protocol);
    end

endmodule

@@ src/tunnel_flow_hash_table_core.sv @@
// Tunnel flow table keyed by source address, destination address and protocol.
// The input channel (in_valid/in_ready) carries one command word: add, delete
// or find, with the key and a tunnel id. The output channel (out_valid/out_ready)
// returns exactly one result word per command: a status and, for a successful
// find, the matching tunnel id. Commands are handled one at a time; in_ready is
// low while a command is in progress.
// After a command is accepted, the key is hashed and the bucket fill count is read;
// the ways below the fill count are then compared in turn until a hit or the end
// of the bucket. An add shifts the stored entries up a way and writes a new head
// entry; a delete shifts the entries after the hit down a way. A successful add or
// delete updates the fill count, and the result is loaded into the output register.
// One compare unit and the single read port of the entry memory are stepped across
// the ways. The next word is accepted once the result is in the output register.
// After reset a clearing pass writes every bucket fill count to zero, one bucket
// per cycle, before the first command is accepted.
// Entry storage itself is not cleared; only ways below the fill count are read.
// When the receiver stalls, the result is held in the output register and the
// next finished command waits for it to drain.
module tunnel_flow_hash_table_core #(
    parameter int SLOT_BITS   = 5,
    parameter int BUCKET_WAYS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [7:0]  protocol,
    input  logic [15:0] tunnel_id,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] found_id
);

    import tfh_pkg::*;

    localparam int BUCKET_CNT = 1 << SLOT_BITS;
    localparam int ENTRY_CNT  = BUCKET_CNT * BUCKET_WAYS;
    localparam int ENTRY_AW   = $clog2(ENTRY_CNT);
    localparam int FILL_W     = $clog2(BUCKET_WAYS + 1);
    localparam int ENT_W      = $bits(entry_t);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_FILL_WAIT,
        S_FILL_CAP,
        S_SCAN,
        S_CMP,
        S_MOVE_RD,
        S_MOVE_WR,
        S_HEAD,
        S_FILL_UPD,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_BITS-1:0] clr_reg, clr_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [31:0]          src_reg, src_next;
    logic [31:0]          dst_reg, dst_next;
    logic [7:0]           proto_reg, proto_next;
    logic [15:0]          id_reg, id_next;
    logic [SLOT_BITS-1:0] bucket_reg, bucket_next;
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [FILL_W-1:0]    cur_reg, cur_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [15:0]          res_found_reg, res_found_next;
    logic                 out_valid_reg, out_valid_next;
    logic [1:0]           status_reg, status_next;
    logic [15:0]          found_reg, found_next;

    logic [31:0]          hash_val;
    logic [ENTRY_AW-1:0]  base;
    logic [FILL_W:0]      cur_plus2;
    logic                 bucket_full;

    logic                 fill_we;
    logic [SLOT_BITS-1:0] fill_waddr;
    logic [FILL_W-1:0]    fill_wdata;
    logic [FILL_W-1:0]    fill_rdata;

    logic                 ent_we;
    logic [ENTRY_AW-1:0]  ent_waddr;
    entry_t               ent_wdata;
    logic [ENTRY_AW-1:0]  ent_raddr;
    logic [ENT_W-1:0]     ent_rbits;
    entry_t               ent_rdata;
    cmp_t                 hit;

    assign hash_val    = key_hash(src_reg, dst_reg, proto_reg);
    assign base        = ENTRY_AW'(bucket_reg) * ENTRY_AW'(BUCKET_WAYS);
    assign cur_plus2   = {1'b0, cur_reg} + (FILL_W + 1)'(2);
    assign bucket_full = (fill_reg == FILL_W'(BUCKET_WAYS));
    assign ent_rdata   = entry_t'(ent_rbits);

    tfh_ram #(
        .DATA_W (FILL_W),
        .DEPTH  (BUCKET_CNT),
        .ADDR_W (SLOT_BITS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .raddr (bucket_reg),
        .rdata (fill_rdata)
    );

    tfh_ram #(
        .DATA_W (ENT_W),
        .DEPTH  (ENTRY_CNT),
        .ADDR_W (ENTRY_AW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rbits)
    );

    tfh_cmp u_cmp (
        .ent       (ent_rdata),
        .src_addr  (src_reg),
        .dst_addr  (dst_reg),
        .protocol  (proto_reg),
        .tunnel_id (id_reg),
        .result    (hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cmd_next        = cmd_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        proto_next      = proto_reg;
        id_next         = id_reg;
        bucket_next     = bucket_reg;
        fill_next       = fill_reg;
        cur_next        = cur_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg;
        status_next     = status_reg;
        found_next      = found_reg;

        fill_we    = 1'b0;
        fill_waddr = bucket_reg;
        fill_wdata = fill_reg;
        ent_we     = 1'b0;
        ent_waddr  = base + ENTRY_AW'(cur_reg);
        ent_wdata  = ent_rdata;
        ent_raddr  = base + ENTRY_AW'(cur_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
                clr_next   = clr_reg + SLOT_BITS'(1);
                if (clr_reg == SLOT_BITS'(BUCKET_CNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = command;
                    src_next   = src_addr;
                    dst_next   = dst_addr;
                    proto_next = protocol;
                    id_next    = tunnel_id;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                bucket_next = hash_val[SLOT_BITS-1:0];
                state_next  = S_FILL_WAIT;
            end
            S_FILL_WAIT:
            begin
                state_next = S_FILL_CAP;
            end
            S_FILL_CAP:
            begin
                fill_next       = fill_rdata;
                cur_next        = '0;
                res_status_next = ST_NOT_FOUND;
                res_found_next  = '0;
                if (cmd_reg == CMD_ADD || cmd_reg == CMD_DEL || cmd_reg == CMD_FIND)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (cur_reg == fill_reg)
                begin
                    if (cmd_reg == CMD_ADD)
                    begin
                        if (bucket_full)
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else if (fill_reg == '0)
                        begin
                            state_next = S_HEAD;
                        end
                        else
                        begin
                            state_next = S_MOVE_RD;
                        end
                    end
                    else
                    begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (cmd_reg == CMD_FIND && hit.key_hit)
                begin
                    res_status_next = ST_OK;
                    res_found_next  = ent_rdata.id;
                    state_next      = S_DONE;
                end
                else if (cmd_reg == CMD_ADD && hit.id_hit)
                begin
                    res_status_next = ST_PRESENT;
                    state_next      = S_DONE;
                end
                else if (cmd_reg == CMD_DEL && hit.id_hit)
                begin
                    if ({1'b0, cur_reg} + (FILL_W + 1)'(1) < {1'b0, fill_reg})
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        state_next = S_FILL_UPD;
                    end
                end
                else
                begin
                    cur_next   = cur_reg + FILL_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_MOVE_RD:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    ent_raddr = base + ENTRY_AW'(cur_reg - FILL_W'(1));
                end
                else
                begin
                    ent_raddr = base + ENTRY_AW'(cur_reg + FILL_W'(1));
                end
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                ent_we    = 1'b1;
                ent_wdata = ent_rdata;
                if (cmd_reg == CMD_ADD)
                begin
                    cur_next = cur_reg - FILL_W'(1);
                    if (cur_reg == FILL_W'(1))
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_MOVE_RD;
                    end
                end
                else
                begin
                    cur_next = cur_reg + FILL_W'(1);
                    if (cur_plus2 < {1'b0, fill_reg})
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        state_next = S_FILL_UPD;
                    end
                end
            end
            S_HEAD:
            begin
                ent_we          = 1'b1;
                ent_waddr       = base;
                ent_wdata.src   = src_reg;
                ent_wdata.dst   = dst_reg;
                ent_wdata.proto = proto_reg;
                ent_wdata.id    = id_reg;
                state_next      = S_FILL_UPD;
            end
            S_FILL_UPD:
            begin
                fill_we = 1'b1;
                if (cmd_reg == CMD_ADD)
                begin
                    fill_wdata = fill_reg + FILL_W'(1);
                end
                else
                begin
                    fill_wdata = fill_reg - FILL_W'(1);
                end
                res_status_next = ST_OK;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    found_next     = res_found_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            found_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        proto_reg      <= proto_next;
        id_reg         <= id_next;
        bucket_reg     <= bucket_next;
        fill_reg       <= fill_next;
        cur_reg        <= cur_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found_id  = found_reg;

    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_HASH && !in_ready)
        else $error("accepted word did not start a command");

    a_cmp_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> cur_reg < fill_reg)
        else $error("compare beyond bucket fill");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL_UPD && cmd_reg == CMD_ADD |-> !bucket_full)
        else $error("add into full bucket");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL_UPD && cmd_reg != CMD_ADD |-> fill_reg != '0)
        else $error("delete from empty bucket");

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && (!out_valid_reg || out_ready) |=> out_valid_reg && in_ready)
        else $error("result not delivered on completion");

endmodule
